/* sv/gos_pkg.sv */
// Package for the one-max generation step: widths, types and gene helpers.
// No dependencies; used by every other file of the block.
`timescale 1ns / 1ps
`default_nettype none
package gos_pkg;
    localparam int PopSize  = 16;
    localparam int GeneBits = 8;
    localparam int SlotW    = $clog2(PopSize);
    localparam int FitW     = $clog2(GeneBits + 1);
    localparam int PointW   = 3;

    typedef enum logic [0:0] {FUNC_LOAD = 1'b0, FUNC_GEN = 1'b1} t_func;
    typedef enum logic [2:0] {
        ST_IDLE, ST_SCAN, ST_MUTATE, ST_WRITE, ST_REPORT, ST_OUT
    } t_state;

    typedef struct packed {
        logic [0:0]          func;
        logic [SlotW-1:0]    load_index;
        logic [GeneBits-1:0] load_genes;
        logic [PointW-1:0]   cross_point;
        logic                mutate;
        logic [PointW-1:0]   mutate_point_a;
        logic [PointW-1:0]   mutate_point_b;
    } t_in;

    typedef struct packed {
        logic [FitW-1:0]     best_fitness;
        logic [GeneBits-1:0] best_genes;
        logic [SlotW-1:0]    best_slot;
        logic                solved;
        logic [SlotW-1:0]    replaced_slot;
    } t_out;

    // One entry travelling along the cell ring.
    typedef struct packed {
        logic [GeneBits-1:0] genes;
        logic [FitW-1:0]     fit;
    } t_entry;

    // Control from the sequencer to every cell.
    typedef struct packed {
        logic                shift;
        logic                load;
        logic [GeneBits-1:0] genes;
        logic [FitW-1:0]     fit;
    } t_cell_ctl;

    function automatic logic [FitW-1:0] count_ones(input logic [GeneBits-1:0] g);
        logic [FitW-1:0] c;
        c = '0;
        for (int i = 0; i < GeneBits; i++) c = c + FitW'(g[i]);
        return c;
    endfunction

    function automatic logic [GeneBits-1:0] below_mask(input logic [PointW-1:0] n);
        logic [GeneBits-1:0] m;
        for (int i = 0; i < GeneBits; i++) m[i] = (i < int'(n));
        return m;
    endfunction

    function automatic logic [GeneBits-1:0] flip(input logic [GeneBits-1:0] g,
                                                 input logic [PointW-1:0] p);
        logic [GeneBits-1:0] r;
        r = g;
        for (int i = 0; i < GeneBits; i++) if (int'(p) == i) r[i] = ~g[i];
        return r;
    endfunction
endpackage
`default_nettype wire

/* sv/gos_if.sv */
// Valid/ready channel interfaces for input and result items.
// Depends on gos_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface gos_in_if;
    logic          valid;
    logic          ready;
    gos_pkg::t_in  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface gos_out_if;
    logic          valid;
    logic          ready;
    gos_pkg::t_out data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

/* sv/gos_cell.sv */
// One population cell: holds one entry, passes it to its neighbor on shift.
// Depends on gos_pkg.
`timescale 1ns / 1ps
`default_nettype none
module gos_cell (
    input  wire                     i_clk,
    input  wire gos_pkg::t_cell_ctl i_ctl,
    input  wire                     i_sel,
    input  wire gos_pkg::t_entry    i_prev,
    output gos_pkg::t_entry         o_entry
);
    gos_pkg::t_entry r_entry;
    gos_pkg::t_entry n_entry;

    // Rotate on shift, take a new entry when selected.
    always_comb begin
        n_entry = r_entry;
        if (i_ctl.shift) begin
            n_entry = i_prev;
        end else if (i_ctl.load && i_sel) begin
            n_entry.genes = i_ctl.genes;
            n_entry.fit   = i_ctl.fit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;
endmodule
`default_nettype wire

/* sv/genetic_onemax_generation_step_top.sv */
// Top level of the one-max generation step: cell ring plus scan sequencer.
// Depends on gos_pkg, gos_if and gos_cell.
//
// Usage: items enter on i_in (valid/ready); each gives one result on o_out.
// A load item writes its slot at the accepting edge, then the ring of 16
// cells rotates once to find the new best; the result is then registered
// and the next item is taken only when the sequencer is back in idle.
// A generation item rotates the ring once while a scanner at cell 0
// tracks the fittest, runner-up and least fit slots, then builds the
// children, writes one slot and rotates once more to find the new best
// before the result is registered. The ring rotates by one slot per
// cycle while it scans.
// Reset clears the sequencer only; slots are undefined until loaded.
// The result waits in an output register while the receiver stalls; the
// next item is still taken and processed, and it holds in its last state
// until the output register is free.
`timescale 1ns / 1ps
`default_nettype none
module genetic_onemax_generation_step_top (
    input  wire          i_clk,
    input  wire          i_rst_n,
    gos_in_if.sink       i_in,
    gos_out_if.source    o_out
);
    localparam int SW = gos_pkg::SlotW;
    localparam int GB = gos_pkg::GeneBits;
    localparam int FW = gos_pkg::FitW;

    gos_pkg::t_state r_state, n_state;
    gos_pkg::t_in    r_item, n_item;
    logic [SW:0]     r_cnt, n_cnt;
    logic [SW-1:0]   r_pos, n_pos;         // slot index currently at cell 0
    logic [SW-1:0]   r_top, n_top, r_run, n_run, r_low, n_low;
    gos_pkg::t_entry r_te, n_te, r_re, n_re, r_le, n_le;
    logic            r_have, n_have;
    logic [SW-1:0]   r_repl, n_repl;
    logic [GB-1:0]   r_ca, n_ca, r_cb, n_cb;
    gos_pkg::t_out   r_out, n_out;
    logic            r_ov, n_ov;
    gos_pkg::t_cell_ctl ctl;

    gos_pkg::t_entry cells [gos_pkg::PopSize];
    logic [SW-1:0]   load_slot;

    // Ring of cells; cell k holds slot (r_pos + k) mod PopSize.
    for (genvar k = 0; k < gos_pkg::PopSize; k++) begin : g_cell
        gos_cell u_cell (
            .i_clk  (i_clk),
            .i_ctl  (ctl),
            .i_sel  (load_slot == SW'(k)),
            .i_prev (cells[(k + 1) % gos_pkg::PopSize]),
            .o_entry(cells[k])
        );
    end

    gos_pkg::t_entry head;
    logic [FW-1:0]   fa, fb;
    logic [GB-1:0]   m;
    assign head = cells[0];
    assign m    = gos_pkg::below_mask(r_item.cross_point);
    assign fa   = gos_pkg::count_ones(r_ca);
    assign fb   = gos_pkg::count_ones(r_cb);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gos_pkg::ST_IDLE;
            r_ov    <= 1'b0;
            r_pos   <= '0;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
            r_pos   <= n_pos;
        end
        r_item <= n_item; r_cnt <= n_cnt;
        r_top <= n_top; r_run <= n_run; r_low <= n_low;
        r_te <= n_te; r_re <= n_re; r_le <= n_le; r_have <= n_have;
        r_repl <= n_repl; r_ca <= n_ca; r_cb <= n_cb; r_out <= n_out;
    end

    // Sequencer: scan the ring, build children, write back, report.
    always_comb begin
        n_state = r_state; n_item = r_item; n_cnt = r_cnt; n_pos = r_pos;
        n_top = r_top; n_run = r_run; n_low = r_low;
        n_te = r_te; n_re = r_re; n_le = r_le; n_have = r_have;
        n_repl = r_repl; n_ca = r_ca; n_cb = r_cb; n_out = r_out; n_ov = r_ov;
        ctl = '0;
        load_slot = '0;
        i_in.ready = (r_state == gos_pkg::ST_IDLE);
        if (o_out.ready) n_ov = 1'b0;
        unique case (r_state)
            gos_pkg::ST_IDLE: begin
                if (i_in.valid && i_in.ready) begin
                    n_item = i_in.data;
                    n_cnt = '0;
                    n_have = 1'b0;
                    if (i_in.data.func == gos_pkg::FUNC_LOAD) begin
                        n_repl = i_in.data.load_index;
                        load_slot = i_in.data.load_index - r_pos;
                        ctl.load = 1'b1;
                        ctl.genes = i_in.data.load_genes;
                        ctl.fit = gos_pkg::count_ones(i_in.data.load_genes);
                        n_state = gos_pkg::ST_REPORT;
                    end else begin
                        n_state = gos_pkg::ST_SCAN;
                    end
                end
            end
            gos_pkg::ST_SCAN: begin
                // Top: last max; low: last min (slot order ascending).
                ctl.shift = 1'b1;
                n_pos = r_pos + 1'b1;
                if (r_cnt == '0 || head.fit >= r_te.fit) begin
                    n_top = r_pos; n_te = head;
                end
                if (r_cnt == '0 || head.fit <= r_le.fit) begin
                    n_low = r_pos; n_le = head;
                end
                // Runner-up: first max among slots other than the top.
                // Demoted top becomes runner if strictly better.
                if (r_cnt != '0 && head.fit >= r_te.fit) begin
                    if (!r_have || r_te.fit > r_re.fit) begin
                        n_run = r_top; n_re = r_te; n_have = 1'b1;
                    end
                end else if (r_cnt != '0) begin
                    if (!r_have || head.fit > r_re.fit) begin
                        n_run = r_pos; n_re = head; n_have = 1'b1;
                    end
                end
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == (SW+1)'(gos_pkg::PopSize - 1)) n_state = gos_pkg::ST_MUTATE;
            end
            gos_pkg::ST_MUTATE: begin
                n_ca = (r_te.genes & ~m) | (r_re.genes & m);
                n_cb = (r_re.genes & ~m) | (r_te.genes & m);
                if (r_item.mutate) begin
                    n_ca = gos_pkg::flip(n_ca, r_item.mutate_point_a);
                    n_cb = gos_pkg::flip(n_cb, r_item.mutate_point_b);
                end
                n_state = gos_pkg::ST_WRITE;
            end
            gos_pkg::ST_WRITE: begin
                load_slot = r_low - r_pos;
                ctl.load = 1'b1;
                if (fa > fb) begin
                    ctl.genes = r_ca; ctl.fit = fa;
                end else begin
                    ctl.genes = r_cb; ctl.fit = fb;
                end
                n_repl = r_low;
                n_state = gos_pkg::ST_REPORT;
            end
            gos_pkg::ST_REPORT: begin
                ctl.shift = 1'b1;
                n_pos = r_pos + 1'b1;
                if (r_cnt == '0 || head.fit >= r_te.fit) begin
                    n_top = r_pos; n_te = head;
                end
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == (SW+1)'(gos_pkg::PopSize - 1)) n_state = gos_pkg::ST_OUT;
            end
            gos_pkg::ST_OUT: begin
                // Hold until the output register is free.
                if (!r_ov || o_out.ready) begin
                    n_out.best_fitness  = r_te.fit;
                    n_out.best_genes    = r_te.genes;
                    n_out.best_slot     = r_top;
                    n_out.solved        = (r_te.fit == FW'(GB));
                    n_out.replaced_slot = r_repl;
                    n_ov = 1'b1;
                    n_state = gos_pkg::ST_IDLE;
                end
            end
            default: n_state = gos_pkg::ST_IDLE;
        endcase
        // Second pass starts its count fresh.
        if (r_state == gos_pkg::ST_WRITE ||
            (r_state == gos_pkg::ST_IDLE && n_state == gos_pkg::ST_REPORT)) begin
            n_cnt = '0;
        end
    end

    assign o_out.valid = r_ov;
    assign o_out.data  = r_out;
endmodule
`default_nettype wire
